>>> hw/rtl/mbt_pkg.sv
// Shared types and constants for the escape-time tile block.
// Holds the multiplier-set operand and product records and the register indexes.
// No dependencies.
package mbt_pkg;

   localparam int INDEX_W = 9;
   localparam int COORD_W = 32;
   localparam int PROD_W  = 64;
   localparam int COUNT_W = 8;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_REAL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CENTER_IMAG = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_SPAN   = 2'd2;

   localparam logic [30:0] HALF_SPAN_RESET = 31'd134217728;

   // Three operand pairs presented to the shared multiplier set.
   typedef struct packed {
      logic signed [COORD_W-1:0] a0;
      logic signed [COORD_W-1:0] b0;
      logic signed [COORD_W-1:0] a1;
      logic signed [COORD_W-1:0] b1;
      logic signed [COORD_W-1:0] a2;
      logic signed [COORD_W-1:0] b2;
   } cmul_ops_type;

   // Registered exact products, available in the cycle after the operands.
   typedef struct packed {
      logic signed [PROD_W-1:0] p0;
      logic signed [PROD_W-1:0] p1;
      logic signed [PROD_W-1:0] p2;
   } cmul_prod_type;

endpackage

>>> hw/rtl/mbt_cmul.sv
// Shared multiplier set: three signed 32x32 multipliers with registered products.
// Depends on mbt_pkg for the operand and product records.
module mbt_cmul (
   input  logic                  clock,
   input  mbt_pkg::cmul_ops_type ops,
   output mbt_pkg::cmul_prod_type prod
);

   mbt_pkg::cmul_prod_type prod_ff;
   mbt_pkg::cmul_prod_type prod_in;

   always_comb begin
      prod_in.p0 = ops.a0 * ops.b0;
      prod_in.p1 = ops.a1 * ops.b1;
      prod_in.p2 = ops.a2 * ops.b2;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> hw/rtl/mbt_step_div.sv
// Pixel step unit: step = dividend / DIVISOR by reciprocal multiplication.
// Done rises in the cycle after start. No package dependency.
module mbt_step_div #(
   parameter int DIVISOR = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   output logic        done,
   output logic [31:0] quotient
);

   // floor(x / d) == (x * m) >> (32 + l) for every 32-bit x,
   // with l = ceil(log2 d) and m = floor(2^(32+l) / d) + 1 (33 bits).
   localparam int          SHIFT = 32 + $clog2(DIVISOR);
   localparam logic [32:0] RECIP = 33'(((64'd1 << SHIFT) / DIVISOR) + 1);

   logic        done_ff, done_in;
   logic [31:0] quo_ff, quo_in;
   logic [64:0] scaled;

   always_comb begin
      scaled  = {33'd0, dividend} * {32'd0, RECIP};
      quo_in  = start ? 32'(scaled >> SHIFT) : quo_ff;
      done_in = start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> hw/rtl/mandelbrot_escape_time_tile.sv
// Escape-time tile pixel engine: sequencer, coordinate set-up and iteration update.
// Depends on mbt_pkg, mbt_cmul (shared multipliers) and mbt_step_div (step divider).
//
// Usage:
//   csr_*  : register writes (index 0 centre real, 1 centre imag, 2 half span),
//            always ready; write only while no request is in flight.
//   req_*  : one request names a pixel by column and row; taken only when the
//            engine is idle, one request at a time.
//   rsp_*  : one escape count per request, held in an output register until
//            taken; a new request is accepted while that result still waits.
// Order: a taken request passes S_CPROD and S_CINIT, then one S_MUL/S_UPD pass per
//   update plus one for the final test (at most 255 updates, the cap), then S_DONE;
//   after reset or a half span write, S_DIV first recomputes the step.
// Each update passes S_MUL, through the shared multiplier set (zr^2, zi^2, zr*zi),
//   then S_UPD, for the escape test, rescaling and saturation.
// Reset: registers return to centre 0, half span 2.0; the step is marked stale.
// While a stalled receiver leaves a count in the output register, a newly finished
//   count parks the engine in its done state; it accepts no request until that is taken.
module mandelbrot_escape_time_tile #(
   parameter int TILE_SIZE = 512,
   parameter int MAX_ITER  = 255
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mbt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [31:0]                        csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mbt_pkg::INDEX_W-1:0]        req_pixel_col,
   input  logic [mbt_pkg::INDEX_W-1:0]        req_pixel_row,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mbt_pkg::COUNT_W-1:0]        rsp_escape_count
);

   localparam logic [mbt_pkg::COUNT_W-1:0] COUNT_CAP = mbt_pkg::COUNT_W'(MAX_ITER);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_CPROD, S_CINIT, S_MUL, S_UPD, S_DONE
   } state_type;

   // Saturate a 40-bit signed sum to the Q6.26 range.
   function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647)
         r = 32'sh7FFFFFFF;
      else if (v < -40'sd2147483648)
         r = 32'sh80000000;
      else
         r = v[31:0];
      return r;
   endfunction

   state_type                 state_ff, state_in;
   logic signed [31:0]        center_real_ff, center_real_in;
   logic signed [31:0]        center_imag_ff, center_imag_in;
   logic [30:0]               half_span_ff, half_span_in;
   logic [31:0]               step_ff, step_in;
   logic                      step_ok_ff, step_ok_in;
   logic [mbt_pkg::INDEX_W-1:0] col_ff, col_in, row_ff, row_in;
   logic signed [31:0]        cr_ff, cr_in, ci_ff, ci_in;
   logic signed [31:0]        zr_ff, zr_in, zi_ff, zi_in;
   logic [mbt_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [mbt_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   mbt_pkg::cmul_ops_type     ops;
   mbt_pkg::cmul_prod_type    prod;
   logic                      div_start;
   logic                      div_done;
   logic [31:0]               div_quo;

   logic                      csr_write;
   logic                      req_take;
   logic signed [39:0]        base_re, base_im;
   logic [64:0]               mag_sum;
   logic                      escaped;
   logic signed [63:0]        re_diff;
   logic signed [63:0]        re_shift, im_shift;

   mbt_cmul u_cmul (
      .clock (clock),
      .ops   (ops),
      .prod  (prod)
   );

   mbt_step_div #(
      .DIVISOR (TILE_SIZE)
   ) u_step_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({half_span_ff, 1'b0}),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign div_start = req_take && !step_ok_ff;

   // Route the multiplier set: index times step during set-up, z products otherwise.
   always_comb begin
      if (state_ff == S_CPROD) begin
         ops.a0 = signed'({23'd0, col_ff});
         ops.b0 = signed'(step_ff);
         ops.a1 = signed'({23'd0, row_ff});
         ops.b1 = signed'(step_ff);
      end else begin
         ops.a0 = zr_ff;
         ops.b0 = zr_ff;
         ops.a1 = zi_ff;
         ops.b1 = zi_ff;
      end
      ops.a2 = zr_ff;
      ops.b2 = zi_ff;
   end

   // Arithmetic on the registered products.
   always_comb begin
      // corner of the tile plus index times step
      base_re = 40'(center_real_ff) - signed'({9'd0, half_span_ff}) + prod.p0[39:0];
      base_im = 40'(center_imag_ff) - signed'({9'd0, half_span_ff}) + prod.p1[39:0];
      // both squares are non-negative, so one sum covers the escape test
      mag_sum  = {1'b0, prod.p0} + {1'b0, prod.p1};
      escaped  = |mag_sum[64:54];
      // shift right arithmetically: rounds toward minus infinity
      re_diff  = prod.p0 - prod.p1;
      re_shift = re_diff >>> 26;
      im_shift = prod.p2 >>> 25;
   end

   always_comb begin
      state_in       = state_ff;
      center_real_in = center_real_ff;
      center_imag_in = center_imag_ff;
      half_span_in   = half_span_ff;
      step_in        = step_ff;
      step_ok_in     = step_ok_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      cr_in          = cr_ff;
      ci_in          = ci_ff;
      zr_in          = zr_ff;
      zi_in          = zi_ff;
      count_in       = count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_count_in   = rsp_count_ff;

      if (csr_write) begin
         case (csr_index)
            mbt_pkg::CSR_CENTER_REAL: center_real_in = signed'(csr_wdata);
            mbt_pkg::CSR_CENTER_IMAG: center_imag_in = signed'(csr_wdata);
            mbt_pkg::CSR_HALF_SPAN: begin
               half_span_in = csr_wdata[30:0];
               step_ok_in   = 1'b0;
            end
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               col_in   = req_pixel_col;
               row_in   = req_pixel_row;
               state_in = step_ok_ff ? S_CPROD : S_DIV;
            end
         end
         S_DIV: begin
            // wait for the step divider
            if (div_done) begin
               step_in    = div_quo;
               step_ok_in = 1'b1;
               state_in   = S_CPROD;
            end
         end
         S_CPROD: state_in = S_CINIT;
         S_CINIT: begin
            cr_in    = sat40(base_re);
            ci_in    = sat40(base_im);
            zr_in    = sat40(base_re);
            zi_in    = sat40(base_im);
            count_in = '0;
            state_in = S_MUL;
         end
         S_MUL: state_in = S_UPD;
         S_UPD: begin
            // cap test ahead of escape test
            if (count_ff == COUNT_CAP || escaped) begin
               state_in = S_DONE;
            end else begin
               zr_in    = sat40(40'(cr_ff) + re_shift[39:0]);
               zi_in    = sat40(40'(ci_ff) + im_shift[39:0]);
               count_in = count_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = count_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         center_real_ff <= '0;
         center_imag_ff <= '0;
         half_span_ff   <= mbt_pkg::HALF_SPAN_RESET;
         step_ok_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         center_real_ff <= center_real_in;
         center_imag_ff <= center_imag_in;
         half_span_ff   <= half_span_in;
         step_ok_ff     <= step_ok_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      step_ff      <= step_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      cr_ff        <= cr_in;
      ci_ff        <= ci_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_escape_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_ready)
      else $error("engine still idle after taking a request");

   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD) |-> (count_ff <= COUNT_CAP))
      else $error("iteration count beyond cap");

   a_div_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("step divider finished outside its wait state");

   a_result_capped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff <= COUNT_CAP))
      else $error("result above cap");
`endif

endmodule
